### rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset
`define ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define ASSERT_NXT(lbl, ck, rs, ante, cons, msg)

`endif

`endif

### rtl/nnu_pkg.sv
package nnu_pkg;

  // Kind of an output unit
  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_PAD    = 2'd1,
    KIND_REJECT = 2'd2
  } unit_kind_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_SCALE = 1'b0,
    CFG_WIDTH = 1'b1
  } cfg_reg_t;

  // Input action codes
  localparam logic ACT_PUSH    = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  localparam int PIX_W   = 24;
  localparam int SCALE_W = 7;
  localparam int WIDTH_W = 13;

  // Result descriptor handed from control to the output stages
  typedef struct packed {
    logic       valid;
    unit_kind_t kind;
    logic       eor;
    logic       eog;
  } unit_meta_t;

endpackage

### rtl/nnu_line_mem.sv
module nnu_line_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [nnu_pkg::PIX_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [nnu_pkg::PIX_W-1:0] rdata
);

  logic [nnu_pkg::PIX_W-1:0] mem [DEPTH];

  // Store one pixel
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/nnu_ctrl.sv
`include "assert_macros.svh"

module nnu_ctrl #(
  parameter int MAX_ROW_WIDTH = 4096,
  parameter int MAX_SCALE     = 100,
  parameter int AW            = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration writes
  input  logic                        cfg_wr,
  input  logic                        cfg_index,
  input  logic [nnu_pkg::WIDTH_W-1:0] cfg_data,
  // accepted input item
  input  logic                        accept,
  input  logic                        action,
  input  logic [nnu_pkg::PIX_W-1:0]   pixel,
  // line memory access
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [nnu_pkg::PIX_W-1:0]   mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  // result descriptor for this item
  output nnu_pkg::unit_meta_t         meta
);

  localparam int IW = $clog2(MAX_ROW_WIDTH + 1);
  localparam int SW = $clog2(MAX_SCALE + 1);

  logic [nnu_pkg::SCALE_W-1:0] scale_factor;
  logic [nnu_pkg::WIDTH_W-1:0] row_width;

  logic          emit_phase, emit_phase_next;
  logic [IW-1:0] load_index, load_index_next;
  logic [IW-1:0] read_index, read_index_next;
  logic [SW-1:0] pixel_cnt, pixel_cnt_next;
  logic [SW-1:0] row_cnt, row_cnt_next;
  logic [1:0]    pad_cnt, pad_cnt_next;

  logic [SW-1:0] f;
  logic [IW-1:0] w;
  logic [1:0]    wf_mod;
  logic [1:0]    pad_needed;
  logic [IW-1:0] load_inc, read_inc;
  logic [SW-1:0] pixel_inc, row_inc;
  logic [1:0]    pad_inc;
  logic          row_end;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= nnu_pkg::SCALE_W'(1);
      row_width    <= nnu_pkg::WIDTH_W'(1);
    end else if (cfg_wr) begin
      unique case (nnu_pkg::cfg_reg_t'(cfg_index))
        nnu_pkg::CFG_SCALE: scale_factor <= cfg_data[nnu_pkg::SCALE_W-1:0];
        nnu_pkg::CFG_WIDTH: row_width    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp factor and width to their working ranges
  always_comb begin
    if (scale_factor == '0) begin
      f = SW'(1);
    end else if (int'(scale_factor) > MAX_SCALE) begin
      f = SW'(MAX_SCALE);
    end else begin
      f = SW'(scale_factor);
    end
    if (row_width == '0) begin
      w = IW'(1);
    end else if (int'(row_width) > MAX_ROW_WIDTH) begin
      w = IW'(MAX_ROW_WIDTH);
    end else begin
      w = IW'(row_width);
    end
    // pad bytes = -(3*w*f) mod 4
    wf_mod     = 2'(2'(w) * 2'(f));
    pad_needed = 2'(2'd0 - 2'(wf_mod * 2'd3));
  end

  assign load_inc  = load_index + IW'(1);
  assign read_inc  = read_index + IW'(1);
  assign pixel_inc = pixel_cnt + SW'(1);
  assign row_inc   = row_cnt + SW'(1);
  assign pad_inc   = pad_cnt + 2'd1;

  assign mem_waddr = load_index[AW-1:0];
  assign mem_wdata = pixel;
  assign mem_raddr = read_index[AW-1:0];

  // Sequence load and emit phases
  always_comb begin
    emit_phase_next = emit_phase;
    load_index_next = load_index;
    read_index_next = read_index;
    pixel_cnt_next  = pixel_cnt;
    row_cnt_next    = row_cnt;
    pad_cnt_next    = pad_cnt;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    row_end         = 1'b0;
    meta.valid      = 1'b0;
    meta.kind       = nnu_pkg::KIND_REJECT;
    meta.eor        = 1'b0;
    meta.eog        = 1'b0;

    if (accept) begin
      if (!emit_phase) begin
        if (action == nnu_pkg::ACT_ADVANCE) begin
          meta.valid = 1'b1;
        end else begin
          mem_we = 1'b1;
          if (load_inc >= w) begin
            load_index_next = '0;
            emit_phase_next = 1'b1;
            read_index_next = '0;
            pixel_cnt_next  = '0;
            row_cnt_next    = '0;
            pad_cnt_next    = '0;
          end else begin
            load_index_next = load_inc;
          end
        end
      end else if (action == nnu_pkg::ACT_PUSH) begin
        meta.valid = 1'b1;
      end else begin
        meta.valid = 1'b1;
        if (read_index < w) begin
          meta.kind = nnu_pkg::KIND_PIXEL;
          mem_re    = 1'b1;
          if (pixel_inc >= f) begin
            pixel_cnt_next  = '0;
            read_index_next = read_inc;
            row_end         = (read_inc >= w) && (pad_needed == 2'd0);
          end else begin
            pixel_cnt_next = pixel_inc;
          end
        end else begin
          meta.kind    = nnu_pkg::KIND_PAD;
          pad_cnt_next = pad_inc;
          row_end      = (pad_inc >= pad_needed);
        end

        // Close the output row, and the group after the last repeat
        if (row_end) begin
          meta.eor        = 1'b1;
          read_index_next = '0;
          pixel_cnt_next  = '0;
          pad_cnt_next    = '0;
          if (row_inc >= f) begin
            row_cnt_next    = '0;
            meta.eog        = 1'b1;
            emit_phase_next = 1'b0;
            load_index_next = '0;
          end else begin
            row_cnt_next = row_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_phase <= 1'b0;
      load_index <= '0;
      read_index <= '0;
      pixel_cnt  <= '0;
      row_cnt    <= '0;
      pad_cnt    <= '0;
    end else begin
      emit_phase <= emit_phase_next;
      load_index <= load_index_next;
      read_index <= read_index_next;
      pixel_cnt  <= pixel_cnt_next;
      row_cnt    <= row_cnt_next;
      pad_cnt    <= pad_cnt_next;
    end
  end

  `ASSERT_IMP(a_load_clean, clk, rst, !emit_phase, (read_index == '0) && (pixel_cnt == '0) && (pad_cnt == '0) && (row_cnt == '0), "emit counters not cleared in load phase")
  `ASSERT_IMP(a_emit_load_idle, clk, rst, emit_phase, load_index == '0, "load index moved during emit phase")
  `ASSERT_NXT(a_row_full, clk, rst, accept && !emit_phase && (action == nnu_pkg::ACT_PUSH) && (load_inc >= w), emit_phase, "full row did not start emit phase")
  `ASSERT_IMP(a_no_rw, clk, rst, 1'b1, !(mem_we && mem_re), "line memory read and write in one cycle")

endmodule

### rtl/nnu_out.sv
`include "assert_macros.svh"

module nnu_out (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  nnu_pkg::unit_meta_t         meta,
  input  logic [nnu_pkg::PIX_W-1:0]   mem_rdata,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [nnu_pkg::PIX_W-1:0]   out_data,
  output logic [2:0]                  out_user,
  output logic                        out_last
);

  logic                s1_valid;
  nnu_pkg::unit_meta_t s1_meta;
  logic                out_free;
  logic                s1_adv;

  assign out_free = !out_valid || out_ready;
  assign s1_adv   = !s1_valid || out_free;
  assign in_ready = s1_adv;

  // Read-wait stage: memory data lands while the descriptor waits here
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= accept && meta.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_meta <= meta;
    end
  end

  // Output register: hold the unit until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_data <= (s1_meta.kind == nnu_pkg::KIND_PIXEL) ? mem_rdata : '0;
      out_user <= {s1_meta.eog, s1_meta.kind};
      out_last <= s1_meta.eor;
    end
  end

  `ASSERT_IMP(a_eog_eor, clk, rst, out_valid && out_user[2], out_last, "group end without row end")
  `ASSERT_IMP(a_zero_data, clk, rst, out_valid && (out_user[1:0] != nnu_pkg::KIND_PIXEL), out_data == '0, "non-pixel unit carries data")
  `ASSERT_IMP(a_reject_flags, clk, rst, out_valid && (out_user[1:0] == nnu_pkg::KIND_REJECT), !out_last && !out_user[2], "rejected unit carries row flags")

endmodule

### rtl/nearest_neighbor_upscaler.sv
// Channel   Dir  Payload (low bit first)                        Transfer
// s_axis    in   tdata: blue, green, red; tuser: action         tvalid & tready
// m_axis    out  tdata: blue, green, red; tuser: kind, grp end  tvalid & tready
//                tlast: end of output row
// cfg       in   index 0 scale_factor, 1 row_width              cfg_valid & cfg_ready
//
// One item per clock in both phases while the output is not stalled; a result
// passes the line memory read stage, then the output register.
// Each emitted pixel costs one read of the line memory.
// Reset clears phase and counters; the line memory is not cleared.
// A stalled output holds the pipeline; input is taken while the output
// register holds a unit, as long as the read stage can move.
module nearest_neighbor_upscaler #(
  parameter int MAX_ROW_WIDTH = 4096,
  parameter int MAX_SCALE     = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // blue, green, red
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_blue, out_green, out_red
  output logic [2:0]  m_axis_tuser,   // unit_kind, end_of_group
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int AW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;

  logic                      accept;
  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  logic [nnu_pkg::PIX_W-1:0] mem_wdata, mem_rdata;
  nnu_pkg::unit_meta_t       meta;

  assign cfg_ready = 1'b1;
  assign accept    = s_axis_tvalid && s_axis_tready;

  nnu_ctrl #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH),
    .MAX_SCALE(MAX_SCALE),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg_wr(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .accept(accept),
    .action(s_axis_tuser),
    .pixel(s_axis_tdata),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re(mem_re),
    .mem_raddr(mem_raddr),
    .meta(meta)
  );

  nnu_line_mem #(
    .DEPTH(MAX_ROW_WIDTH),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  nnu_out u_out (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .meta(meta),
    .mem_rdata(mem_rdata),
    .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data(m_axis_tdata),
    .out_user(m_axis_tuser),
    .out_last(m_axis_tlast)
  );

endmodule

### verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIDTH     = 4096;
  localparam int MAX_FACTOR    = 100;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 300;

  // One output unit as the checker sees it
  typedef struct packed {
    nnu_pkg::unit_kind_t kind;
    logic                eor;
    logic                eog;
    logic [23:0]         pix;
  } unit_t;

  localparam unit_t REJECT_UNIT = '{nnu_pkg::KIND_REJECT, 1'b0, 1'b0, 24'h0};
  localparam unit_t NO_UNIT     = '{nnu_pkg::KIND_PIXEL, 1'b0, 1'b0, 24'h0};

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed plan: a register write or an input item
  typedef struct {
    row_kind_t         kind;
    nnu_pkg::cfg_reg_t reg_idx;
    logic [12:0]       value;
    logic              act;
    logic [23:0]       pix;
    logic              typed;
    unit_t             exp_unit;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // blue, green, red
  logic        s_axis_tuser = 1'b0; // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // out_blue, out_green, out_red
  logic [2:0]  m_axis_tuser;        // unit_kind, end_of_group
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = nnu_pkg::CFG_SCALE;
  logic [12:0] cfg_data = '0;

  nearest_neighbor_upscaler u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Upscaler state mirrored by the scoreboard
  logic [23:0] line_copy [MAX_WIDTH];
  logic        in_emit   = 1'b0;
  int          load_pos  = 0;
  int          read_pos  = 0;
  int          pix_reps  = 0;
  int          row_reps  = 0;
  int          pad_done  = 0;
  logic [6:0]  scale_reg = 7'd1;
  logic [12:0] width_reg = 13'd1;

  unit_t pending_units [$];
  int    fail_count = 0;
  int    items_sent = 0;
  int    group_no   = 0;
  int    quiet      = 0;
  int    hold_left  = 0;
  int    stall_left = 0;
  logic  hold_req   = 1'b0;
  logic  tx_gaps    = 1'b0;
  logic  rx_stalls  = 1'b1;

  step_t plan [31] = '{
    // after reset: factor 1, width 1
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_ADVANCE, 24'h000000, 1'b1, REJECT_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_PUSH,    24'hFFFFFF, 1'b0, NO_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_PUSH,    24'h000000, 1'b1, REJECT_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_ADVANCE, 24'h000000, 1'b1,
      '{nnu_pkg::KIND_PIXEL, 1'b0, 1'b0, 24'hFFFFFF}},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_ADVANCE, 24'h000000, 1'b1,
      '{nnu_pkg::KIND_PAD, 1'b1, 1'b1, 24'h000000}},
    // zero registers act as one
    '{ROW_CFG,  nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_PUSH,    24'h0,      1'b0, NO_UNIT},
    '{ROW_CFG,  nnu_pkg::CFG_WIDTH, 13'd0, nnu_pkg::ACT_PUSH,    24'h0,      1'b0, NO_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_PUSH,    24'h000000, 1'b0, NO_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_ADVANCE, 24'hFFFFFF, 1'b0, NO_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_ADVANCE, 24'hFFFFFF, 1'b0, NO_UNIT},
    // width lowered mid-load ends the load at the next push
    '{ROW_CFG,  nnu_pkg::CFG_SCALE, 13'd2, nnu_pkg::ACT_PUSH,    24'h0,      1'b0, NO_UNIT},
    '{ROW_CFG,  nnu_pkg::CFG_WIDTH, 13'd4, nnu_pkg::ACT_PUSH,    24'h0,      1'b0, NO_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_PUSH,    24'h123456, 1'b0, NO_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_PUSH,    24'hABCDEF, 1'b0, NO_UNIT},
    '{ROW_CFG,  nnu_pkg::CFG_WIDTH, 13'd2, nnu_pkg::ACT_PUSH,    24'h0,      1'b0, NO_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_PUSH,    24'h5AA55A, 1'b0, NO_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_ADVANCE, 24'h0,      1'b0, NO_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_ADVANCE, 24'h0,      1'b0, NO_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_ADVANCE, 24'h0,      1'b0, NO_UNIT},
    // factor lowered mid-row, counter already past the new limit
    '{ROW_CFG,  nnu_pkg::CFG_SCALE, 13'd1, nnu_pkg::ACT_PUSH,    24'h0,      1'b0, NO_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_ADVANCE, 24'h0,      1'b0, NO_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_ADVANCE, 24'h0,      1'b0, NO_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_ADVANCE, 24'h0,      1'b0, NO_UNIT},
    // padding stage entered when the new factor needs no padding
    '{ROW_CFG,  nnu_pkg::CFG_WIDTH, 13'd1, nnu_pkg::ACT_PUSH,    24'h0,      1'b0, NO_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_PUSH,    24'hC3C3C3, 1'b0, NO_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_ADVANCE, 24'h0,      1'b0, NO_UNIT},
    '{ROW_CFG,  nnu_pkg::CFG_SCALE, 13'd4, nnu_pkg::ACT_PUSH,    24'h0,      1'b0, NO_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_ADVANCE, 24'h0,      1'b0, NO_UNIT},
    '{ROW_CFG,  nnu_pkg::CFG_SCALE, 13'd1, nnu_pkg::ACT_PUSH,    24'h0,      1'b0, NO_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_ADVANCE, 24'h0,      1'b0, NO_UNIT},
    '{ROW_ITEM, nnu_pkg::CFG_SCALE, 13'd0, nnu_pkg::ACT_ADVANCE, 24'h0,      1'b0, NO_UNIT}
  };

  function automatic int eff_scale();
    if (scale_reg == 0) return 1;
    if (scale_reg > MAX_FACTOR) return MAX_FACTOR;
    return int'(scale_reg);
  endfunction

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  // Advance the mirrored state by one item; has is low when no unit follows
  function automatic void predict_unit(input logic act, input logic [23:0] pix,
                                       output logic has, output unit_t u);
    int   f;
    int   w;
    int   pad;
    logic row_end;
    f       = eff_scale();
    w       = eff_width();
    pad     = (4 - ((w * f * 3) & 3)) & 3;
    has     = 1'b1;
    u       = REJECT_UNIT;
    row_end = 1'b0;
    if (!in_emit) begin
      if (act == nnu_pkg::ACT_ADVANCE) return;
      has = 1'b0;
      if (load_pos < MAX_WIDTH) line_copy[load_pos] = pix;
      load_pos++;
      if (load_pos >= w) begin
        load_pos = 0;
        in_emit  = 1'b1;
        read_pos = 0;
        pix_reps = 0;
        row_reps = 0;
        pad_done = 0;
      end
      return;
    end
    if (act == nnu_pkg::ACT_PUSH) return;
    if (read_pos < w) begin
      u = '{nnu_pkg::KIND_PIXEL, 1'b0, 1'b0, line_copy[read_pos]};
      pix_reps++;
      if (pix_reps >= f) begin
        pix_reps = 0;
        read_pos++;
        row_end  = (read_pos >= w) && (pad == 0);
      end
    end else begin
      u = '{nnu_pkg::KIND_PAD, 1'b0, 1'b0, 24'h0};
      pad_done++;
      row_end = (pad_done >= pad);
    end
    if (row_end) begin
      read_pos = 0;
      pix_reps = 0;
      pad_done = 0;
      row_reps++;
      u.eor    = 1'b1;
      if (row_reps >= f) begin
        row_reps = 0;
        u.eog    = 1'b1;
        in_emit  = 1'b0;
        load_pos = 0;
      end
    end
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] %s mismatch: got %0h, expected %0h", $realtime, field, got, want);
    fail_count++;
  endtask

  // Offer one item and hold it until the transfer
  task automatic send_item(input logic act, input logic [23:0] pix,
                           input logic typed, input unit_t typed_unit);
    logic  has;
    unit_t u;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= pix;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    predict_unit(act, pix, has, u);
    if (has) pending_units.push_back(typed ? typed_unit : u);
    items_sent++;
  endtask

  // Drop valid, drain every expected unit, then let the pipeline settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input nnu_pkg::cfg_reg_t idx, input logic [12:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == nnu_pkg::CFG_SCALE) scale_reg = val[6:0];
    else width_reg = val;
    @(posedge clk);
  endtask

  task automatic sender_gap();
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Load one row and emit its whole group, with a little wrong-phase noise and optional register changes
  task automatic run_group(input logic tweaks);
    logic act;
    while (!in_emit) begin
      act = ($urandom_range(0, 19) == 0) ? nnu_pkg::ACT_ADVANCE : nnu_pkg::ACT_PUSH;
      sender_gap();
      send_item(act, 24'($urandom()), 1'b0, NO_UNIT);
    end
    while (in_emit) begin
      // Registers changed mid-row; width only shrinks so no unwritten entry is read
      if (tweaks && $urandom_range(0, 60) == 0)
        set_reg(nnu_pkg::CFG_SCALE, 13'($urandom_range(1, 4)));
      else if (tweaks && $urandom_range(0, 80) == 0)
        set_reg(nnu_pkg::CFG_WIDTH, 13'($urandom_range(1, eff_width())));
      act = ($urandom_range(0, 19) == 0) ? nnu_pkg::ACT_PUSH : nnu_pkg::ACT_ADVANCE;
      sender_gap();
      send_item(act, 24'($urandom()), 1'b0, NO_UNIT);
    end
  endtask

  // Check each output transfer and pace tready
  always @(posedge clk) begin : rx_side
    unit_t want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (pending_units.size() == 0) begin
        report_mismatch("unexpected unit, unit_kind", int'(m_axis_tuser[1:0]), 0);
      end else begin
        want = pending_units.pop_front();
        if (m_axis_tuser[1:0] !== want.kind)
          report_mismatch("unit_kind", int'(m_axis_tuser[1:0]), int'(want.kind));
        if (m_axis_tdata[7:0] !== want.pix[7:0])
          report_mismatch("out_blue", int'(m_axis_tdata[7:0]), int'(want.pix[7:0]));
        if (m_axis_tdata[15:8] !== want.pix[15:8])
          report_mismatch("out_green", int'(m_axis_tdata[15:8]), int'(want.pix[15:8]));
        if (m_axis_tdata[23:16] !== want.pix[23:16])
          report_mismatch("out_red", int'(m_axis_tdata[23:16]), int'(want.pix[23:16]));
        if (m_axis_tlast !== want.eor)
          report_mismatch("end_of_out_row", int'(m_axis_tlast), int'(want.eor));
        if (m_axis_tuser[2] !== want.eog)
          report_mismatch("end_of_group", int'(m_axis_tuser[2]), int'(want.eog));
      end
    end
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // End the run when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int          rand_start;
    logic [6:0]  scale_pick;
    logic [12:0] width_pick;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed plan
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG)
        set_reg(plan[i].reg_idx, plan[i].value);
      else
        send_item(plan[i].act, plan[i].pix, plan[i].typed, plan[i].exp_unit);
    end

    // Random groups: mostly small rows and factors, some out-of-range settings
    rand_start = items_sent;
    while ((items_sent - rand_start < RANDOM_ITEMS) || (group_no < 5)) begin
      group_no++;
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0:       scale_pick = 7'd0;
          1:       scale_pick = 7'($urandom_range(5, 6));
          default: scale_pick = 7'($urandom_range(1, 3));
        endcase
        set_reg(nnu_pkg::CFG_SCALE, {6'($urandom()), scale_pick});
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0:       width_pick = 13'd0;
          1:       width_pick = 13'($urandom_range(12, 24));
          default: width_pick = 13'($urandom_range(1, 8));
        endcase
        set_reg(nnu_pkg::CFG_WIDTH, width_pick);
      end
      // Sender waits for every expected unit once
      if (group_no == 3) wait_idle();
      // Receiver holds off while the sender keeps offering
      if (group_no == 5) begin
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
      end
      run_group(1'b1);
    end

    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;

    // Factor above its range, raised mid-row: a pixel repeats MAX_FACTOR times
    set_reg(nnu_pkg::CFG_SCALE, 13'd1);
    set_reg(nnu_pkg::CFG_WIDTH, 13'd1);
    send_item(nnu_pkg::ACT_PUSH, 24'($urandom()), 1'b0, NO_UNIT);
    set_reg(nnu_pkg::CFG_SCALE, 13'h1FFF);
    repeat (MAX_FACTOR) send_item(nnu_pkg::ACT_ADVANCE, 24'h0, 1'b0, NO_UNIT);
    set_reg(nnu_pkg::CFG_SCALE, 13'd1);
    run_group(1'b0);

    // Upper write bits dropped, with no idling on either side
    set_reg(nnu_pkg::CFG_SCALE, 13'h1F83);
    set_reg(nnu_pkg::CFG_WIDTH, 13'd8);
    run_group(1'b0);

    wait_idle();
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
